// ===== hdl/ant_pkg.sv =====
// Shared constants, codes and control types for the account name table.
// No dependencies; every other file in hdl/ imports this package.
package ant_pkg;

  // Fixed payload widths
  localparam int BYTE_W  = 8;
  localparam int QUERY_W = 16;

  // Defaults for the top-level parameters
  localparam int MAX_ENTRIES_DEF = 128;
  localparam int NAME_MAX_DEF    = 14;
  localparam int ID_BITS_DEF     = 16;

  // Request kinds carried in the mode field
  localparam logic MODE_PARSE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // Characters the parser and the result path care about
  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_QMARK = 8'h3F;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic parse;   // consume one file byte
    logic start;   // latch query id, rewind the id scan
    logic scan;    // advance the id scan by one entry
    logic put;     // load one name byte into the result register
    logic single;  // load the one-byte result (empty name or miss)
  } ant_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic match;       // id read back this cycle matches the query
    logic match_empty; // matching entry has an empty name
    logic exhausted;   // every stored entry has been compared
    logic name_last;   // byte being loaded is the last of the name
  } ant_stat_t;

endpackage

// ===== hdl/ant_if.sv =====
// Valid/ready request and result channels of the account name table.
// Depends on ant_pkg for payload widths.
interface ant_in_if;
  import ant_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [BYTE_W-1:0]  data_byte;
  logic [QUERY_W-1:0] query_id;

  modport source (output valid, mode, data_byte, query_id, input ready);
  modport sink   (input valid, mode, data_byte, query_id, output ready);
endinterface

interface ant_out_if;
  import ant_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] name_char;
  logic              found;
  logic              last;

  modport source (output valid, name_char, found, last, input ready);
  modport sink   (input valid, name_char, found, last, output ready);
endinterface

// ===== hdl/ant_ctrl.sv =====
// Sequencer of the account name table: request handshake, id scan,
// name streaming and the result valid flag. Depends on ant_pkg.
module ant_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_mode,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ant_pkg::ant_cmd_t cmd,
  input  ant_pkg::ant_stat_t stat
);
  import ant_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_FETCH  = 3'd2;
  localparam logic [2:0] S_PUT    = 3'd3;
  localparam logic [2:0] S_SINGLE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && in_mode == MODE_PARSE) begin
          cmd.parse = 1'b1;
        end else if (accept && in_mode == MODE_LOOKUP) begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.match) begin
          state_next = stat.match_empty ? S_SINGLE : S_FETCH;
        end else if (stat.exhausted) begin
          state_next = S_SINGLE;
        end
      end
      // name memory read settles for the new byte address
      S_FETCH: begin
        state_next = S_PUT;
      end
      S_PUT: begin
        if (out_free) begin
          cmd.put    = 1'b1;
          state_next = stat.name_last ? S_IDLE : S_FETCH;
        end
      end
      S_SINGLE: begin
        if (out_free) begin
          cmd.single = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.put || cmd.single) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/ant_dp.sv =====
// Datapath of the account name table: line parser, id/length/name
// memories, id scan pipeline and result register. Depends on ant_pkg.
module ant_dp #(
  parameter int MAX_ENTRIES = ant_pkg::MAX_ENTRIES_DEF,
  parameter int NAME_MAX    = ant_pkg::NAME_MAX_DEF,
  parameter int ID_BITS     = ant_pkg::ID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ant_pkg::ant_cmd_t            cmd,
  output ant_pkg::ant_stat_t           stat,
  input  logic [ant_pkg::BYTE_W-1:0]   data_byte,
  input  logic [ant_pkg::QUERY_W-1:0]  query_id,
  output logic [ant_pkg::BYTE_W-1:0]   name_char,
  output logic                         found,
  output logic                         last
);
  import ant_pkg::*;

  localparam int EW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int PW    = $clog2(NAME_MAX + 1);
  localparam int NDEPTH = MAX_ENTRIES * NAME_MAX;
  localparam int NAW   = $clog2(NDEPTH);

  localparam logic [2:0] PH_START      = 3'd0;
  localparam logic [2:0] PH_NAME       = 3'd1;
  localparam logic [2:0] PH_SKIP_FIELD = 3'd2;
  localparam logic [2:0] PH_ID         = 3'd3;
  localparam logic [2:0] PH_SKIP_LINE  = 3'd4;

  // Storage
  logic [ID_BITS-1:0] id_mem   [MAX_ENTRIES];
  logic [PW-1:0]      len_mem  [MAX_ENTRIES];
  logic [BYTE_W-1:0]  name_mem [NDEPTH];

  // Parser state
  logic [2:0]         parse_phase, parse_phase_next;
  logic [PW-1:0]      name_pos, name_pos_next;
  logic               stopped, stopped_next;
  logic [CW-1:0]      entry_count, entry_count_next;
  logic [NAW-1:0]     new_base, new_base_next;
  logic [EW-1:0]      cur_idx, cur_idx_next;
  logic [NAW-1:0]     cur_base, cur_base_next;
  logic [ID_BITS-1:0] acc_id, acc_id_next;

  // Per-byte working values
  logic [EW-1:0]      eff_idx;
  logic [NAW-1:0]     eff_base;
  logic [PW-1:0]      eff_pos;
  logic [2:0]         eff_ph;
  logic [ID_BITS-1:0] acc_x10;
  logic [3:0]         digit;
  logic               is_digit;

  // Memory write ports
  logic               id_we, len_we, name_we;
  logic [ID_BITS-1:0] id_wdata;
  logic [PW-1:0]      len_wdata;
  logic [NAW-1:0]     name_waddr;

  // Lookup state
  logic [ID_BITS-1:0] qid;
  logic [CW-1:0]      scan_idx;
  logic [NAW-1:0]     scan_base;
  logic               rd_valid;
  logic [NAW-1:0]     rd_base;
  logic [ID_BITS-1:0] id_rd;
  logic [PW-1:0]      len_rd;
  logic               hit;
  logic [NAW-1:0]     hit_base;
  logic [PW-1:0]      hit_len;
  logic [PW-1:0]      out_k;
  logic [NAW-1:0]     name_raddr;
  logic [BYTE_W-1:0]  name_rd;

  assign digit    = 4'(data_byte - CHAR_ZERO);
  assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
  assign acc_x10  = (acc_id << 3) + (acc_id << 1);

  // Parser: one file byte per cycle while no lookup is in progress
  always_comb begin
    parse_phase_next = parse_phase;
    name_pos_next    = name_pos;
    stopped_next     = stopped;
    entry_count_next = entry_count;
    new_base_next    = new_base;
    cur_idx_next     = cur_idx;
    cur_base_next    = cur_base;
    acc_id_next      = acc_id;
    eff_idx          = cur_idx;
    eff_base         = cur_base;
    eff_pos          = name_pos;
    eff_ph           = parse_phase;
    id_we            = 1'b0;
    id_wdata         = '0;
    len_we           = 1'b0;
    len_wdata        = '0;
    name_we          = 1'b0;
    if (cmd.parse && !stopped) begin
      if (data_byte == CHAR_NUL) begin
        stopped_next = 1'b1;
      end else if (parse_phase == PH_START && entry_count >= CW'(MAX_ENTRIES)) begin
        stopped_next = 1'b1;
      end else begin
        // first byte of a line opens a fresh entry
        if (parse_phase == PH_START) begin
          eff_idx          = entry_count[EW-1:0];
          eff_base         = new_base;
          eff_pos          = '0;
          eff_ph           = PH_NAME;
          entry_count_next = entry_count + CW'(1);
          new_base_next    = new_base + NAW'(NAME_MAX);
          cur_idx_next     = entry_count[EW-1:0];
          cur_base_next    = new_base;
          acc_id_next      = '0;
          name_pos_next    = '0;
          parse_phase_next = PH_NAME;
          id_we            = 1'b1;
          len_we           = 1'b1;
        end
        unique case (eff_ph)
          PH_NAME: begin
            if (data_byte == CHAR_COLON) begin
              parse_phase_next = PH_SKIP_FIELD;
            end else if (eff_pos < PW'(NAME_MAX)) begin
              name_we       = 1'b1;
              name_pos_next = eff_pos + PW'(1);
              len_we        = 1'b1;
              len_wdata     = eff_pos + PW'(1);
            end
          end
          PH_SKIP_FIELD: begin
            if (data_byte == CHAR_COLON) begin
              parse_phase_next = PH_ID;
            end
          end
          PH_ID: begin
            if (is_digit) begin
              acc_id_next = acc_x10 + ID_BITS'(digit);
              id_we       = 1'b1;
              id_wdata    = acc_id_next;
            end else begin
              parse_phase_next = PH_SKIP_LINE;
            end
          end
          PH_SKIP_LINE: begin
            if (data_byte == CHAR_LF) begin
              parse_phase_next = PH_START;
            end
          end
          default: begin
            parse_phase_next = PH_START;
          end
        endcase
      end
    end
  end

  assign name_waddr = eff_base + NAW'(eff_pos);

  // Parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= PH_START;
      name_pos    <= '0;
      stopped     <= 1'b0;
      entry_count <= '0;
      new_base    <= '0;
    end else begin
      parse_phase <= parse_phase_next;
      name_pos    <= name_pos_next;
      stopped     <= stopped_next;
      entry_count <= entry_count_next;
      new_base    <= new_base_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_idx  <= cur_idx_next;
    cur_base <= cur_base_next;
    acc_id   <= acc_id_next;
  end

  // Id and length memories, read by the scan
  always_ff @(posedge clk) begin
    if (id_we) begin
      id_mem[eff_idx] <= id_wdata;
    end
    id_rd <= id_mem[scan_idx[EW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[eff_idx] <= len_wdata;
    end
    len_rd <= len_mem[scan_idx[EW-1:0]];
  end

  // Name memory, read by the streaming stage
  assign name_raddr = hit_base + NAW'(out_k);

  always_ff @(posedge clk) begin
    if (name_we) begin
      name_mem[name_waddr] <= data_byte;
    end
    name_rd <= name_mem[name_raddr];
  end

  // Scan: one entry address issued per cycle, compared once the registered id read returns
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (cmd.start) begin
      rd_valid <= 1'b0;
    end else if (cmd.scan) begin
      rd_valid <= (scan_idx < entry_count);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qid       <= ID_BITS'(query_id);
      scan_idx  <= '0;
      scan_base <= '0;
      hit       <= 1'b0;
      out_k     <= '0;
    end else begin
      if (cmd.scan && scan_idx < entry_count) begin
        scan_idx  <= scan_idx + CW'(1);
        scan_base <= scan_base + NAW'(NAME_MAX);
        rd_base   <= scan_base;
      end
      if (cmd.scan && stat.match) begin
        hit      <= 1'b1;
        hit_base <= rd_base;
        hit_len  <= len_rd;
      end
      if (cmd.put) begin
        out_k <= out_k + PW'(1);
      end
    end
  end

  assign stat.match       = rd_valid && (id_rd == qid);
  assign stat.match_empty = (len_rd == '0);
  assign stat.exhausted   = !rd_valid && (scan_idx == entry_count);
  assign stat.name_last   = ((out_k + PW'(1)) == hit_len);

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.put) begin
      name_char <= name_rd;
      found     <= 1'b1;
      last      <= stat.name_last;
    end else if (cmd.single) begin
      name_char <= hit ? CHAR_NUL : CHAR_QMARK;
      found     <= hit;
      last      <= 1'b1;
    end
  end

endmodule

// ===== hdl/account_name_table.sv =====
// Account name table: parses account-file bytes into an id/name table and
// answers id lookups with the stored name, one byte per result.
//
// Channels: req (sink) carries mode, data_byte and query_id; rsp (source)
// carries name_char, found and last. A request moves on a clock edge with
// valid and ready both high; the same holds for a result.
// A parse request (mode 0) gives no result; the block is ready for the next
// request on the following cycle.
// A lookup (mode 1) scans the id memory one entry per cycle over the stored
// entries (at most MAX_ENTRIES) and stops at the first match; it then streams
// the name, each byte through a fetch state and a put state, pausing while
// the receiver stalls. Requests are not taken while a lookup is in progress.
// A stalled receiver holds the result register; streaming pauses until the
// pending byte is taken. A parse request is still taken while a result waits.
// Reset (rst, synchronous) empties the table and restarts parsing at a line
// start; no memory clearing pass is needed.
module account_name_table #(
  parameter int MAX_ENTRIES = ant_pkg::MAX_ENTRIES_DEF,
  parameter int NAME_MAX    = ant_pkg::NAME_MAX_DEF,
  parameter int ID_BITS     = ant_pkg::ID_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  ant_in_if.sink   req,
  ant_out_if.source rsp
);
  import ant_pkg::*;

  ant_cmd_t  cmd;
  ant_stat_t stat;

  // Sequencer
  ant_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_mode   (req.mode),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Parser, storage and result path
  ant_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .NAME_MAX    (NAME_MAX),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .data_byte (req.data_byte),
    .query_id  (req.query_id),
    .name_char (rsp.name_char),
    .found     (rsp.found),
    .last      (rsp.last)
  );

`ifndef SYNTHESIS
  // a lookup holds off further requests on the next cycle
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.mode == MODE_LOOKUP) |=> !req.ready)
    else $error("request taken straight after a lookup");

  // parse requests never create a result
  a_parse_silent: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.mode == MODE_PARSE && !rsp.valid) |=> !rsp.valid)
    else $error("result appeared after a parse request");

  // a miss is always a single, final result
  a_miss_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.found) |-> rsp.last)
    else $error("miss result not marked last");

  // at most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.parse, cmd.start, cmd.scan, cmd.put, cmd.single}))
    else $error("conflicting datapath commands");
`endif

endmodule

// ===== bench/testbench.sv =====
// Testbench for account_name_table: parses account lines, looks up ids and
// checks every streamed name byte. Needs ant_pkg, ant_in_if/ant_out_if and the block.
`timescale 1ns / 1ps

module testbench;
  import ant_pkg::*;

  localparam int TABLE_DEPTH     = MAX_ENTRIES_DEF;
  localparam int NAME_LEN        = NAME_MAX_DEF;
  localparam int DIRECTED_ROWS   = 27;
  localparam int RANDOM_REQUESTS = 200;
  localparam int QUIET_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 32;

  typedef struct packed {
    logic [BYTE_W-1:0] name_char;
    logic              found;
    logic              last;
  } name_result_t;

  typedef struct packed {
    logic               mode;
    logic [BYTE_W-1:0]  data;
    logic [QUERY_W-1:0] qid;
    logic               typed;   // result typed in below, not predicted
    name_result_t       result;
  } stim_row_t;

  typedef enum logic [2:0] {
    LINE_START, IN_NAME, SKIP_PASSWORD, IN_ID, SKIP_REST
  } line_phase_t;

  localparam name_result_t NO_MATCH   = '{CHAR_QMARK, 1'b0, 1'b1};
  localparam name_result_t EMPTY_NAME = '{CHAR_NUL, 1'b1, 1'b1};
  localparam name_result_t NONE       = '0;

  logic clk = 1'b0;
  logic rst;
  logic take_result = 1'b0;

  ant_in_if  req_ch ();
  ant_out_if rsp_ch ();

  assign rsp_ch.ready = take_result;

  account_name_table uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Table as the block should hold it
  line_phase_t        line_phase = LINE_START;
  int unsigned        name_pos = 0;
  int unsigned        entry_count = 0;
  bit                 parse_halted = 1'b0;
  logic [QUERY_W-1:0] acct_id [TABLE_DEPTH];
  int unsigned        name_len [TABLE_DEPTH];
  logic [BYTE_W-1:0]  acct_name [TABLE_DEPTH][NAME_LEN];

  name_result_t name_results_due [$];
  int unsigned  mismatch_count = 0;
  int unsigned  requests_sent = 0;
  int unsigned  burst_left = 0;
  int unsigned  quiet_cycles = 0;
  logic [15:0]  pattern_pos = '0;
  logic [7:0]   ready_mask = 8'hFF;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("[%0t] mismatch: %s", $time, what);
  endtask

  // One file byte through the line parser
  function automatic void parse_account_byte(input logic [BYTE_W-1:0] c);
    int unsigned cur;
    if (parse_halted)
      return;
    if (c == CHAR_NUL) begin
      parse_halted = 1'b1;
      return;
    end
    if (line_phase == LINE_START) begin
      // first byte of a line opens an entry, unless the table is full
      if (entry_count >= TABLE_DEPTH) begin
        parse_halted = 1'b1;
        return;
      end
      acct_id[entry_count]  = '0;
      name_len[entry_count] = 0;
      entry_count++;
      name_pos   = 0;
      line_phase = IN_NAME;
    end
    cur = entry_count - 1;
    case (line_phase)
      IN_NAME: begin
        if (c == CHAR_COLON) begin
          line_phase = SKIP_PASSWORD;
        end else if (name_pos < NAME_LEN) begin
          acct_name[cur][name_pos] = c;
          name_pos++;
          name_len[cur] = name_pos;
        end
      end
      SKIP_PASSWORD: begin
        if (c == CHAR_COLON)
          line_phase = IN_ID;
      end
      IN_ID: begin
        // wraps at the id width on assignment
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
          acct_id[cur] = acct_id[cur] * 10 + (c - CHAR_ZERO);
        else
          line_phase = SKIP_REST;
      end
      SKIP_REST: begin
        if (c == CHAR_LF)
          line_phase = LINE_START;
      end
      default: line_phase = LINE_START;
    endcase
  endfunction

  // Name bytes of the first entry holding the id
  function automatic void predict_lookup(input logic [QUERY_W-1:0] qid);
    int unsigned idx;
    int unsigned k;
    bit          hit;
    hit = 1'b0;
    for (idx = 0; idx < entry_count; idx++) begin
      if (acct_id[idx] == qid) begin
        hit = 1'b1;
        break;
      end
    end
    if (!hit) begin
      name_results_due.push_back(NO_MATCH);
    end else if (name_len[idx] == 0) begin
      name_results_due.push_back(EMPTY_NAME);
    end else begin
      for (k = 0; k < name_len[idx]; k++)
        name_results_due.push_back('{acct_name[idx][k], 1'b1, k + 1 == name_len[idx]});
    end
  endfunction

  // Mostly ids already stored, sometimes the top id or anything
  function automatic logic [QUERY_W-1:0] pick_query();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (entry_count != 0 && sel < 7)
      return acct_id[$urandom_range(0, entry_count - 1)];
    if (sel == 7)
      return '1;
    return QUERY_W'($urandom_range(0, 16'hFFFF));
  endfunction

  // Sender: bursts of random length with random gaps between them
  task automatic drive_request(input logic m, input logic [BYTE_W-1:0] b,
                               input logic [QUERY_W-1:0] q, input logic typed,
                               input name_result_t typed_res);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    req_ch.valid     <= 1'b1;
    req_ch.mode      <= m;
    req_ch.data_byte <= b;
    req_ch.query_id  <= q;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    burst_left--;
    requests_sent++;
    if (m == MODE_PARSE)
      parse_account_byte(b);
    else if (typed)
      name_results_due.push_back(typed_res);
    else
      predict_lookup(q);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    drive_request(MODE_PARSE, b, QUERY_W'($urandom_range(0, 16'hFFFF)), 1'b0, NONE);
  endtask

  task automatic send_lookup(input logic [QUERY_W-1:0] q);
    drive_request(MODE_LOOKUP, BYTE_W'($urandom_range(0, 255)), q, 1'b0, NONE);
  endtask

  // Walk the parser back to a line start with as few bytes as it takes
  task automatic finish_line();
    while (!parse_halted && line_phase != LINE_START)
      send_byte(line_phase == SKIP_REST ? CHAR_LF : CHAR_COLON);
  endtask

  // name:password:id:rest, with random content
  task automatic emit_account_line();
    int unsigned       sel;
    int unsigned       name_bytes;
    int unsigned       k;
    logic [BYTE_W-1:0] c;
    sel = $urandom_range(0, 9);
    if (sel == 0)
      name_bytes = $urandom_range(NAME_LEN, NAME_LEN + 2);
    else if (sel == 1)
      name_bytes = 0;
    else
      name_bytes = $urandom_range(1, 8);
    for (k = 0; k < name_bytes; k++) begin
      if ($urandom_range(0, 4) != 0) begin
        c = BYTE_W'($urandom_range(8'h61, 8'h7A));
      end else begin
        c = BYTE_W'($urandom_range(1, 255));
        if (c == CHAR_COLON)
          c = 8'h5F;
      end
      send_byte(c);
    end
    send_byte(CHAR_COLON);
    repeat ($urandom_range(0, 3)) send_byte(BYTE_W'($urandom_range(8'h61, 8'h7A)));
    send_byte(CHAR_COLON);
    repeat ($urandom_range(0, 6)) send_byte(CHAR_ZERO + BYTE_W'($urandom_range(0, 9)));
    if ($urandom_range(0, 6) == 0) begin
      // newline straight after the id: the next line gets swallowed
      send_byte(CHAR_LF);
    end else begin
      send_byte(CHAR_COLON);
      repeat ($urandom_range(0, 3)) send_byte(BYTE_W'($urandom_range(8'h61, 8'h7A)));
      send_byte(CHAR_LF);
    end
  endtask

  // Receiver: check each result, stall on a rotating mask
  always @(posedge clk) begin
    name_result_t exp;
    if (!rst) begin
      if (rsp_ch.valid && take_result) begin
        if (name_results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result name_char=%02h found=%0b last=%0b",
                                    rsp_ch.name_char, rsp_ch.found, rsp_ch.last));
        end else begin
          exp = name_results_due.pop_front();
          if (rsp_ch.name_char !== exp.name_char)
            report_mismatch($sformatf("name_char %02h, want %02h",
                                      rsp_ch.name_char, exp.name_char));
          if (rsp_ch.found !== exp.found)
            report_mismatch($sformatf("found %0b, want %0b", rsp_ch.found, exp.found));
          if (rsp_ch.last !== exp.last)
            report_mismatch($sformatf("last %0b, want %0b", rsp_ch.last, exp.last));
        end
      end
    end
    pattern_pos = pattern_pos + 16'd1;
    if (pattern_pos[5:0] == 6'd0)
      ready_mask = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
    take_result <= ready_mask[pattern_pos[2:0]];
  end

  // Watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && take_result)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("account_name_table verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t directed_rows [DIRECTED_ROWS];
    int unsigned r;

    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.mode      <= MODE_PARSE;
    req_ch.data_byte <= CHAR_NUL;
    req_ch.query_id  <= '0;

    directed_rows = '{
      '{MODE_LOOKUP, CHAR_NUL,             16'h0000, 1'b1, NO_MATCH},   // empty table
      '{MODE_PARSE,  CHAR_COLON,           16'h0000, 1'b0, NONE},       // entry 0, no name
      '{MODE_LOOKUP, CHAR_NUL,             16'h0000, 1'b1, EMPTY_NAME}, // half-built entry
      '{MODE_PARSE,  CHAR_COLON,           16'hFFFF, 1'b0, NONE},
      '{MODE_PARSE,  CHAR_ZERO + 8'd6,     16'h0000, 1'b0, NONE},       // id 65535
      '{MODE_PARSE,  CHAR_ZERO + 8'd5,     16'h0000, 1'b0, NONE},
      '{MODE_PARSE,  CHAR_ZERO + 8'd5,     16'h0000, 1'b0, NONE},
      '{MODE_PARSE,  CHAR_ZERO + 8'd3,     16'h0000, 1'b0, NONE},
      '{MODE_PARSE,  CHAR_ZERO + 8'd5,     16'h0000, 1'b0, NONE},
      '{MODE_PARSE,  CHAR_LF,              16'h0000, 1'b0, NONE},       // ends id, skips a line
      '{MODE_LOOKUP, 8'hFF,                16'hFFFF, 1'b1, EMPTY_NAME},
      '{MODE_PARSE,  8'h78,                16'h0000, 1'b0, NONE},       // swallowed line
      '{MODE_PARSE,  CHAR_LF,              16'h0000, 1'b0, NONE},
      '{MODE_LOOKUP, 8'hA5,                16'h0000, 1'b1, NO_MATCH},
      '{MODE_PARSE,  8'hFF,                16'h0000, 1'b0, NONE},       // entry 1
      '{MODE_PARSE,  CHAR_LF,              16'h0000, 1'b0, NONE},       // no colon yet: kept
      '{MODE_PARSE,  8'h01,                16'h0000, 1'b0, NONE},
      '{MODE_PARSE,  CHAR_COLON,           16'h0000, 1'b0, NONE},
      '{MODE_PARSE,  CHAR_COLON,           16'h0000, 1'b0, NONE},
      '{MODE_PARSE,  CHAR_COLON,           16'h0000, 1'b0, NONE},       // empty id field
      '{MODE_PARSE,  CHAR_LF,              16'h0000, 1'b0, NONE},
      '{MODE_PARSE,  8'h62,                16'h0000, 1'b0, NONE},       // entry 2, id 0 again
      '{MODE_PARSE,  CHAR_COLON,           16'h0000, 1'b0, NONE},
      '{MODE_PARSE,  CHAR_COLON,           16'h0000, 1'b0, NONE},
      '{MODE_PARSE,  CHAR_COLON,           16'h0000, 1'b0, NONE},
      '{MODE_PARSE,  CHAR_LF,              16'h0000, 1'b0, NONE},
      '{MODE_LOOKUP, CHAR_NUL,             16'h0000, 1'b0, NONE}        // first duplicate wins
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < DIRECTED_ROWS; r++)
      drive_request(directed_rows[r].mode, directed_rows[r].data, directed_rows[r].qid,
                    directed_rows[r].typed, directed_rows[r].result);

    // Random: mostly whole lines, some lookups, a little noise
    while (requests_sent < DIRECTED_ROWS + RANDOM_REQUESTS) begin
      r = $urandom_range(0, 99);
      if (r < 60)
        emit_account_line();
      else if (r < 90)
        send_lookup(pick_query());
      else
        repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(1, 255)));
    end

    // Zero byte halts parsing; later bytes must leave the table alone
    finish_line();
    send_byte(CHAR_NUL);
    send_byte(8'h61);
    repeat (3) send_byte(BYTE_W'($urandom_range(1, 255)));
    repeat (12) send_lookup(pick_query());

    req_ch.valid <= 1'b0;
    while (name_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("account_name_table verification clean");
    else
      $display("account_name_table verification failed");
    $finish;
  end

endmodule
